// ===== rtl/dvs_pkg.sv =====
`default_nettype none
package dvs_pkg;

    localparam int CFG_ADDR_W = 5;

    localparam logic [2:0] REG_GAIN     = 3'd0;
    localparam logic [2:0] REG_BAND     = 3'd1;
    localparam logic [2:0] REG_SETTLE   = 3'd2;
    localparam logic [2:0] REG_CHANGE   = 3'd3;
    localparam logic [2:0] REG_INTERVAL = 3'd4;

    localparam logic [16:0] UNITY_GAIN     = 17'h10000;
    localparam logic [16:0] GAIN_RESET     = 17'd32768;
    localparam logic [30:0] BAND_RESET     = 31'd65536;
    localparam logic [31:0] SETTLE_RESET   = 32'd500;
    localparam logic [31:0] CHANGE_RESET   = 32'd500;
    localparam logic [31:0] INTERVAL_RESET = 32'd50;

    typedef struct packed {
        logic [16:0] gain;
        logic [30:0] band_magnitude;
        logic [31:0] settle_duration;
        logic [31:0] change_duration;
        logic [31:0] sample_interval;
    } cfg_t;

    function automatic logic still_running(
        input logic [31:0] start,
        input logic [31:0] duration,
        input logic [31:0] now
    );
        logic [31:0] elapsed;
        elapsed = now - start;
        return elapsed < duration;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dvs_cfg.sv =====
`default_nettype none
module dvs_cfg
    import dvs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = paddr[CFG_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain            <= GAIN_RESET;
            cfg_reg.band_magnitude  <= BAND_RESET;
            cfg_reg.settle_duration <= SETTLE_RESET;
            cfg_reg.change_duration <= CHANGE_RESET;
            cfg_reg.sample_interval <= INTERVAL_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_GAIN:     cfg_reg.gain            <= pwdata[16:0];
                REG_BAND:     cfg_reg.band_magnitude  <= pwdata[30:0];
                REG_SETTLE:   cfg_reg.settle_duration <= pwdata;
                REG_CHANGE:   cfg_reg.change_duration <= pwdata;
                REG_INTERVAL: cfg_reg.sample_interval <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_GAIN:     prdata = {15'd0, cfg_reg.gain};
            REG_BAND:     prdata = {1'b0, cfg_reg.band_magnitude};
            REG_SETTLE:   prdata = cfg_reg.settle_duration;
            REG_CHANGE:   prdata = cfg_reg.change_duration;
            REG_INTERVAL: prdata = cfg_reg.sample_interval;
            default:      prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/dvs_ewma.sv =====
`default_nettype none
module dvs_ewma
    import dvs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               update,
    input  wire logic        [16:0] gain,
    input  wire logic signed [31:0] sample,
    output logic signed      [31:0] average_next
);

    logic signed [31:0] average_reg;
    logic               average_valid_reg;
    logic signed [31:0] base;
    logic        [16:0] g;
    logic signed [17:0] g_s;
    logic signed [32:0] diff;
    logic signed [50:0] prod;
    logic signed [50:0] rounded;
    logic signed [34:0] step;

    // avg + floor((g*(x-avg) + half) / unity)
    assign base         = average_valid_reg ? average_reg : sample;
    assign g            = (gain > UNITY_GAIN) ? UNITY_GAIN : gain;
    assign g_s          = {1'b0, g};
    assign diff         = {sample[31], sample} - {base[31], base};
    assign prod         = g_s * diff;
    assign rounded      = prod + 51'sd32768;
    assign step         = rounded[50:16];
    assign average_next = base + step[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            average_reg       <= 32'sd0;
            average_valid_reg <= 1'b0;
        end
        else if (update)
        begin
            average_reg       <= average_next;
            average_valid_reg <= 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dvs_hold.sv =====
`default_nettype none
module dvs_hold
    import dvs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               update,
    input  wire cfg_t               cfg,
    input  wire logic        [31:0] timestamp,
    input  wire logic signed [31:0] value,
    output logic signed      [31:0] held_next,
    output logic                    held_valid_next
);

    logic signed [31:0] previous_input_reg;
    logic               previous_input_valid_reg;
    logic        [31:0] previous_time_reg;
    logic               changing_timer_on_reg;
    logic               settling_timer_on_reg;
    logic        [31:0] change_start_time_reg;
    logic        [31:0] settle_start_time_reg;
    logic signed [31:0] latched_value_reg;
    logic               latched_valid_reg;
    logic signed [31:0] held_output_reg;
    logic               held_output_valid_reg;

    logic               changing_timer_on_next;
    logic               settling_timer_on_next;
    logic        [31:0] change_start_time_next;
    logic        [31:0] settle_start_time_next;
    logic signed [31:0] latched_value_next;
    logic               latched_valid_next;

    always_comb
    begin
        logic               first;
        logic               ch_on;
        logic               st_on;
        logic               lv;
        logic               hv;
        logic        [31:0] ptime;
        logic signed [31:0] ref_value;
        logic signed [32:0] d;
        logic        [32:0] mag;
        logic               in_band;

        first     = !previous_input_valid_reg;
        ch_on     = changing_timer_on_reg && !first;
        st_on     = settling_timer_on_reg && !first;
        lv        = latched_valid_reg && !first;
        hv        = held_output_valid_reg && !first;
        ptime     = first ? timestamp : previous_time_reg;
        ref_value = lv ? latched_value_reg : previous_input_reg;
        d         = {value[31], value} - {ref_value[31], ref_value};
        mag       = d[32] ? -d : d;
        in_band   = !first && (mag < {2'b00, cfg.band_magnitude});

        changing_timer_on_next = ch_on;
        settling_timer_on_next = st_on;
        change_start_time_next = change_start_time_reg;
        settle_start_time_next = settle_start_time_reg;
        latched_value_next     = latched_value_reg;
        latched_valid_next     = lv;
        held_next              = held_output_reg;
        held_valid_next        = hv;

        if (in_band)
        begin
            changing_timer_on_next = 1'b0;
            settling_timer_on_next = 1'b1;
            if (!st_on)
            begin
                settle_start_time_next = timestamp;
            end
            if (!still_running(settle_start_time_next, cfg.settle_duration, timestamp) &&
                still_running(settle_start_time_next, cfg.settle_duration, ptime))
            begin
                latched_value_next = value;
                latched_valid_next = 1'b1;
                held_next          = value;
                held_valid_next    = 1'b1;
            end
        end
        else
        begin
            settling_timer_on_next = 1'b0;
            changing_timer_on_next = 1'b1;
            if (!ch_on)
            begin
                change_start_time_next = timestamp;
            end
            if (!still_running(change_start_time_next, cfg.change_duration, timestamp))
            begin
                held_next          = value;
                held_valid_next    = 1'b1;
                latched_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_input_reg       <= 32'sd0;
            previous_input_valid_reg <= 1'b0;
            previous_time_reg        <= 32'd0;
            changing_timer_on_reg    <= 1'b0;
            settling_timer_on_reg    <= 1'b0;
            change_start_time_reg    <= 32'd0;
            settle_start_time_reg    <= 32'd0;
            latched_value_reg        <= 32'sd0;
            latched_valid_reg        <= 1'b0;
            held_output_reg          <= 32'sd0;
            held_output_valid_reg    <= 1'b0;
        end
        else if (update)
        begin
            previous_input_reg       <= value;
            previous_input_valid_reg <= 1'b1;
            previous_time_reg        <= timestamp;
            changing_timer_on_reg    <= changing_timer_on_next;
            settling_timer_on_reg    <= settling_timer_on_next;
            change_start_time_reg    <= change_start_time_next;
            settle_start_time_reg    <= settle_start_time_next;
            latched_value_reg        <= latched_value_next;
            latched_valid_reg        <= latched_valid_next;
            held_output_reg          <= held_next;
            held_output_valid_reg    <= held_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/display_value_smoother.sv =====
// Requests pass through an input register, then a result register (out_valid).
// Throughput: one request per cycle while not stalled; the average and hold state update
// in the same cycle as the result is computed, so the next request sees them directly.
// Reset: rst_n asynchronous active low; clears all filter state and restores the
// configuration registers to their reset values.
`default_nettype none
module display_value_smoother
    import dvs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [31:0]           timestamp,
    input  wire logic signed [31:0]    sample,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       status,
    output logic signed [31:0]         smoothed,
    output logic                       smoothed_valid
);

    cfg_t               cfg;
    logic               in_valid_reg;
    logic        [31:0] timestamp_reg;
    logic signed [31:0] sample_reg;
    logic        [31:0] last_accept_time_reg;
    logic               out_valid_reg;
    logic               status_reg;
    logic signed [31:0] smoothed_reg;
    logic               smoothed_valid_reg;
    logic               fire;
    logic               waiting;
    logic               update;
    logic signed [31:0] average_next;
    logic signed [31:0] held_next;
    logic               held_valid_next;

    dvs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;
    assign waiting  = still_running(last_accept_time_reg, cfg.sample_interval, timestamp_reg);
    assign update   = fire && !waiting;

    dvs_ewma u_ewma (
        .clk          (clk),
        .rst_n        (rst_n),
        .update       (update),
        .gain         (cfg.gain),
        .sample       (sample_reg),
        .average_next (average_next)
    );

    dvs_hold u_hold (
        .clk             (clk),
        .rst_n           (rst_n),
        .update          (update),
        .cfg             (cfg),
        .timestamp       (timestamp_reg),
        .value           (average_next),
        .held_next       (held_next),
        .held_valid_next (held_valid_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            last_accept_time_reg <= 32'd0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (update)
            begin
                last_accept_time_reg <= timestamp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            timestamp_reg <= timestamp;
            sample_reg    <= sample;
        end
        if (fire)
        begin
            status_reg         <= waiting;
            smoothed_valid_reg <= !waiting && held_valid_next;
            smoothed_reg       <= (!waiting && held_valid_next) ? held_next : 32'sd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign smoothed       = smoothed_reg;
    assign smoothed_valid = smoothed_valid_reg;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    import dvs_pkg::*;

    localparam logic       ST_OK         = 1'b0;
    localparam logic       ST_WAITING    = 1'b1;
    localparam logic [2:0] REG_UNUSED    = 3'd5;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         PHASES        = 9;
    localparam int         PHASE_ITEMS   = 150;
    localparam int         DIRECTED_ROWS = 19;
    localparam int         DEV           = 12288;
    localparam int         SPREAD        = 40;
    localparam int         LONG_HOLD     = 250;

    typedef struct packed {
        logic        status;
        logic [31:0] smoothed;
        logic        smoothed_valid;
    } display_t;

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] x;
        logic        pinned;
        display_t    want;
    } plan_row_t;

    localparam display_t SKIPPED = '{ST_WAITING, 32'd0, 1'b0};
    localparam display_t BLANK   = '{ST_OK, 32'd0, 1'b0};

    localparam plan_row_t PLAN [DIRECTED_ROWS] = '{
        '{32'd0,          32'h0000_0000, 1'b1, SKIPPED},
        '{32'd49,         32'h7FFF_FFFF, 1'b1, SKIPPED},
        '{32'd50,         32'h7FFF_FFFF, 1'b1, BLANK},
        '{32'd60,         32'h0000_0000, 1'b1, SKIPPED},
        '{32'd100,        32'h8000_0000, 1'b1, BLANK},
        '{32'd700,        32'h0000_0000, 1'b0, BLANK},
        '{32'd800,        32'h0000_0000, 1'b0, BLANK},
        '{32'd1100,       32'h0000_0000, 1'b0, BLANK},
        '{32'd1200,       32'h0010_0000, 1'b0, BLANK},
        '{32'd1800,       32'h0010_0000, 1'b0, BLANK},
        '{32'd1850,       32'hFFFF_FFFF, 1'b0, BLANK},
        '{32'hFFFF_FFFF,  32'h0001_0000, 1'b0, BLANK},
        '{32'h0000_0020,  32'h7FFF_FFFF, 1'b1, SKIPPED},
        '{32'h0000_0031,  32'h8000_0000, 1'b0, BLANK},
        '{32'h0000_0300,  32'hFFFF_FFFF, 1'b0, BLANK},
        '{32'h0000_0600,  32'h0000_0000, 1'b0, BLANK},
        '{32'hAAAA_AAAA,  32'h5555_5555, 1'b0, BLANK},
        '{32'h5555_5555,  32'hAAAA_AAAA, 1'b0, BLANK},
        '{32'h5555_5556,  32'h0000_0000, 1'b1, SKIPPED}
    };

    logic                  clk;
    logic                  rst_n          = 1'b0;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr          = '0;
    logic [31:0]           pwdata         = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid       = 1'b0;
    logic                  in_ready;
    logic [31:0]           timestamp      = '0;
    logic signed [31:0]    sample         = '0;
    logic                  out_valid;
    logic                  out_ready      = 1'b0;
    logic                  status;
    logic signed [31:0]    smoothed;
    logic                  smoothed_valid;

    cfg_t               cfg;
    logic [31:0]        accept_time;
    logic [31:0]        prev_time;
    logic [31:0]        change_t0;
    logic [31:0]        settle_t0;
    logic signed [31:0] avg;
    logic signed [31:0] prev_avg;
    logic signed [31:0] latch_val;
    logic signed [31:0] shown_val;
    logic               avg_ok;
    logic               prev_ok;
    logic               change_on;
    logic               settle_on;
    logic               latch_ok;
    logic               shown_ok;

    display_t    pending_display [$];
    logic [31:0] level;
    int          mismatches  = 0;
    int          gap_pct     = 20;
    int          stall_pct   = 20;
    int          hold_left   = 0;
    int          cycle_count = 0;
    logic        long_hold   = 1'b0;

    display_value_smoother dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] ticks_since(input logic [31:0] t0, input logic [31:0] now);
        return now - t0;
    endfunction

    function automatic logic within_band(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32])
        begin
            d = -d;
        end
        return d < {2'b00, cfg.band_magnitude};
    endfunction

    function automatic void reset_model();
        cfg         = '{GAIN_RESET, BAND_RESET, SETTLE_RESET, CHANGE_RESET, INTERVAL_RESET};
        accept_time = '0;
        prev_time   = '0;
        change_t0   = '0;
        settle_t0   = '0;
        avg         = '0;
        prev_avg    = '0;
        latch_val   = '0;
        shown_val   = '0;
        avg_ok      = 1'b0;
        prev_ok     = 1'b0;
        change_on   = 1'b0;
        settle_on   = 1'b0;
        latch_ok    = 1'b0;
        shown_ok    = 1'b0;
    endfunction

    function automatic display_t predict_display(input logic [31:0] t,
                                                 input logic signed [31:0] x);
        display_t r;
        longint   g;
        longint   acc;
        logic     hit;
        r = '0;
        if (ticks_since(accept_time, t) < cfg.sample_interval)
        begin
            r.status = ST_WAITING;
            return r;
        end
        accept_time = t;
        g = (cfg.gain > UNITY_GAIN) ? longint'(UNITY_GAIN) : longint'(cfg.gain);
        if (!avg_ok)
        begin
            avg    = x;
            avg_ok = 1'b1;
        end
        acc = g * longint'(x) + (longint'(65536) - g) * longint'(avg) + longint'(32768);
        avg = acc[47:16];
        if (!prev_ok)
        begin
            change_on = 1'b0;
            settle_on = 1'b0;
            latch_ok  = 1'b0;
            shown_ok  = 1'b0;
            prev_time = t;
        end
        hit = latch_ok ? within_band(avg, latch_val) : (prev_ok && within_band(avg, prev_avg));
        if (hit)
        begin
            change_on = 1'b0;
            if (!settle_on)
            begin
                settle_t0 = t;
                settle_on = 1'b1;
            end
            if (ticks_since(settle_t0, t) >= cfg.settle_duration &&
                ticks_since(settle_t0, prev_time) < cfg.settle_duration)
            begin
                latch_val = avg;
                latch_ok  = 1'b1;
                shown_val = avg;
                shown_ok  = 1'b1;
            end
        end
        else
        begin
            settle_on = 1'b0;
            if (!change_on)
            begin
                change_t0 = t;
                change_on = 1'b1;
            end
            if (ticks_since(change_t0, t) >= cfg.change_duration)
            begin
                shown_val = avg;
                shown_ok  = 1'b1;
                latch_ok  = 1'b0;
            end
        end
        prev_avg         = avg;
        prev_ok          = 1'b1;
        prev_time        = t;
        r.status         = ST_OK;
        r.smoothed_valid = shown_ok;
        r.smoothed       = shown_ok ? shown_val : 32'd0;
        return r;
    endfunction

    function automatic cfg_t draw_settings(input int phase);
        cfg_t c;
        case (phase)
            0: c = '{GAIN_RESET, BAND_RESET, SETTLE_RESET, CHANGE_RESET, INTERVAL_RESET};
            1: c = '0;
            2: c = '{UNITY_GAIN, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            3: c = '{17'h1FFFF, 31'd3000, 32'd100, 32'd100, 32'd10};
            default:
            begin
                c.gain = 17'($urandom_range(0, 32'h1FFFF));
                case ($urandom_range(0, 2))
                    0:       c.band_magnitude = 31'($urandom_range(1, 32'h20000));
                    1:       c.band_magnitude = 31'($urandom_range(0, 32'h7FFF_FFFF));
                    default: c.band_magnitude = 31'($urandom_range(0, 32'h800));
                endcase
                c.settle_duration = $urandom_range(0, 300);
                c.change_duration = $urandom_range(0, 300);
                c.sample_interval = $urandom_range(0, 40);
            end
        endcase
        return c;
    endfunction

    task automatic note_if_differs(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch on %s: expected %h, got %h", what, want, got);
            end
        end
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_settings();
        logic [31:0] rd;
        apb_access(1'b0, REG_GAIN, '0, rd);
        note_if_differs("gain readback", {15'b0, cfg.gain}, rd);
        apb_access(1'b0, REG_BAND, '0, rd);
        note_if_differs("band readback", {1'b0, cfg.band_magnitude}, rd);
        apb_access(1'b0, REG_SETTLE, '0, rd);
        note_if_differs("settle readback", cfg.settle_duration, rd);
        apb_access(1'b0, REG_CHANGE, '0, rd);
        note_if_differs("change readback", cfg.change_duration, rd);
        apb_access(1'b0, REG_INTERVAL, '0, rd);
        note_if_differs("interval readback", cfg.sample_interval, rd);
    endtask

    task automatic load_settings(input cfg_t c);
        logic [31:0] rd;
        apb_access(1'b1, REG_GAIN, {15'b0, c.gain}, rd);
        apb_access(1'b1, REG_BAND, {1'b0, c.band_magnitude}, rd);
        apb_access(1'b1, REG_SETTLE, c.settle_duration, rd);
        apb_access(1'b1, REG_CHANGE, c.change_duration, rd);
        apb_access(1'b1, REG_INTERVAL, c.sample_interval, rd);
        cfg = c;
        check_settings();
    endtask

    task automatic send_request(input logic [31:0] t, input logic [31:0] x, input logic pinned,
                                input display_t want);
        display_t guess;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        timestamp <= t;
        sample    <= x;
        guess = predict_display(t, x);
        pending_display.push_back(pinned ? want : guess);
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random();
        logic [31:0] t;
        logic [31:0] x;
        int          pick;
        pick = $urandom_range(0, 99);
        t = accept_time + cfg.sample_interval + $urandom_range(0, SPREAD);
        x = level + $urandom_range(0, 2 * DEV) - DEV;
        if (pick < 6)
        begin
            level = $urandom;
            x     = level;
        end
        else if (pick < 60)
        begin
            x = x;
        end
        else if (pick < 72)
        begin
            t = accept_time + $urandom_range(0, cfg.sample_interval);
        end
        else if (pick < 80)
        begin
            t = accept_time + cfg.sample_interval - $urandom_range(0, 1);
        end
        else if (pick < 92)
        begin
            t = $urandom;
            x = $urandom;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       x = 32'h7FFF_FFFF;
                1:       x = 32'h8000_0000;
                2:       x = 32'h0000_0000;
                default: x = 32'hFFFF_FFFF;
            endcase
        end
        send_request(t, x, 1'b0, BLANK);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_display.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                out_ready <= 1'b0;
                hold_left = $urandom_range(0, 3);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        display_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_display.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result with no request pending: status %b smoothed %h valid %b",
                             status, smoothed, smoothed_valid);
                end
            end
            else
            begin
                want = pending_display.pop_front();
                note_if_differs("status", {31'd0, want.status}, {31'd0, status});
                note_if_differs("smoothed", want.smoothed, smoothed);
                note_if_differs("smoothed_valid", {31'd0, want.smoothed_valid},
                                {31'd0, smoothed_valid});
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] rd;
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(1'b1, REG_UNUSED, $urandom, rd);
        check_settings();
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_request(PLAN[i].t, PLAN[i].x, PLAN[i].pinned, PLAN[i].want);
        end
        drain_results();
        for (int p = 0; p < PHASES; p++)
        begin
            load_settings(draw_settings(p));
            gap_pct   = (p == PHASES - 1) ? 0 : 10 * $urandom_range(0, 3);
            stall_pct = (p == PHASES - 1) ? 0 : 10 * $urandom_range(0, 3);
            level     = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold the output side while requests keep coming
                if (p == 4 && n == 40)
                begin
                    long_hold = 1'b1;
                end
                // pause until every pending result is back
                if (p == 5 && n == 75)
                begin
                    drain_results();
                end
                send_random();
            end
            drain_results();
        end
        repeat (4) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
